>>> design/eca_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package eca_pkg;

	localparam int IDX_W    = 6;
	localparam int IDX_SPAN = 1 << IDX_W;
	localparam int OP_W     = 2;
	localparam int RULE_W   = 8;
	localparam int CNT_W    = 16;
	localparam int GEN_W    = 7;
	localparam int GRP      = 8;
	localparam int GRP_W    = 3;
	localparam int NGRP_RD  = IDX_SPAN / GRP;
	localparam int CFG_IDX_W = 1;

	localparam logic [RULE_W-1:0] RULE_RESET = 8'd30;
	localparam logic [GEN_W-1:0]  GEN_MAX    = 7'd127;

	typedef enum logic [OP_W-1:0] {
		OP_WRITE = 2'd0,
		OP_STEP  = 2'd1,
		OP_READ  = 2'd2
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RULE = 1'b0,
		CFG_WRAP = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD1,
		S_RD2,
		S_COUNT,
		S_DONE
	} state_t;

	// control broadcast along the row of cells
	typedef struct packed {
		logic              step;
		logic              wr;
		logic              wr_val;
		logic              wrap;
		logic [IDX_W-1:0]  idx;
	} cell_ctl_t;

endpackage
`default_nettype wire

>>> design/elementary_cellular_automaton_row.sv
`timescale 1ns / 1ps
`default_nettype none
// Row of CELLS one-bit cells stepped by an elementary (three-neighbour) rule.
// Input channel (in_valid / in_stall) carries one transaction per item: op, cell_index,
// cell_value. Output channel (out_valid / out_stall) returns exactly one transaction
// per item: cell_state, cell_changes and the changed-cell count of the last generation.
// Config channel (cfg_valid / cfg_ready, always ready) writes rule_number (index 0) or
// wrap_borders (index 1); write it only while the block is idle.
// Items are processed one at a time; in_stall is high from acceptance until the result
// has moved into the output register.
// Write / read: the result passes the two-level registered read select (S_RD1, S_RD2)
// and then S_DONE. Step: all cells update in the accept cycle; the changed-cell tally
// then sweeps the change flags eight cells per cycle in S_COUNT before S_DONE.
// Unused op code: straight to S_DONE. The next item is taken once back in S_IDLE.
// A stalled receiver holds the result in the output register; the next item is still
// accepted and waits in the last state until the register frees.
// Reset: row all zero except cell CELLS/2, change counters and the generation count
// cleared, rule 30, bounded mode; no clearing pass is needed.
module elementary_cellular_automaton_row
	import eca_pkg::*;
#(
	parameter int CELLS = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [OP_W-1:0]       op,
	input  logic [IDX_W-1:0]      cell_index,
	input  logic                  cell_value,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  cell_state,
	output logic [CNT_W-1:0]      cell_changes,
	output logic [GEN_W-1:0]      generation_changes,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [RULE_W-1:0]     cfg_data
);

	localparam int SUM_W  = $clog2(CELLS + 1);
	localparam int WIDE_W = (SUM_W > GEN_W) ? SUM_W : GEN_W;
	localparam logic [GEN_W-1:0] GEN_CAP =
		(CELLS > 127) ? GEN_MAX : GEN_W'(CELLS);

	// config registers
	logic [RULE_W-1:0] rule_q;
	logic              wrap_q;

	// control
	state_t            state_q, state_d;
	logic              in_acc;
	logic              step_go;
	logic              gen_load;
	logic              out_load;
	logic              from_cell_q;
	logic [IDX_W-1:0]  idx_q;
	logic [GEN_W-1:0]  last_gen_q;

	// row
	cell_ctl_t         ctl;
	logic [CELLS-1:0]  row_w;
	logic [CELLS-1:0]  flip_w;
	logic [CNT_W-1:0]  cnt_w [CELLS];

	// read path
	logic [IDX_SPAN-1:0] rd_states;
	logic [CNT_W-1:0]    rd_counts [IDX_SPAN];
	logic                rd_state;
	logic [CNT_W-1:0]    rd_count;

	// tally
	logic              tally_busy;
	logic [SUM_W-1:0]  tally_total;
	logic [WIDE_W-1:0] total_wide;
	logic [GEN_W-1:0]  total_sat;

	// output register
	logic              out_valid_q;
	logic              out_state_q;
	logic [CNT_W-1:0]  out_changes_q;
	logic [GEN_W-1:0]  out_gen_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rule_q <= RULE_RESET;
			wrap_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				CFG_RULE: rule_q <= cfg_data;
				CFG_WRAP: wrap_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// fsm: next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					case (op_t'(op))
						OP_WRITE, OP_READ: state_d = S_RD1;
						OP_STEP:           state_d = S_COUNT;
						default:           state_d = S_DONE;
					endcase
				end
			end
			S_RD1:   state_d = S_RD2;
			S_RD2:   state_d = S_DONE;
			S_COUNT: if (!tally_busy) state_d = S_DONE;
			S_DONE:  if (!out_valid_q || !out_stall) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// fsm: outputs
	always_comb begin
		in_stall = (state_q != S_IDLE);
		gen_load = (state_q == S_COUNT) && !tally_busy;
		out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall);
	end

	assign in_acc  = in_valid && !in_stall;
	assign step_go = in_acc && (op_t'(op) == OP_STEP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			last_gen_q <= '0;
		end else begin
			state_q <= state_d;
			if (gen_load)
				last_gen_q <= total_sat;
		end
	end

	// item held for the read path and result select
	always_ff @(posedge clk) begin
		if (in_acc) begin
			idx_q       <= cell_index;
			from_cell_q <= (op_t'(op) == OP_WRITE) || (op_t'(op) == OP_READ);
		end
	end

	// broadcast to the cells; writes and steps take effect at acceptance
	assign ctl.step   = step_go;
	assign ctl.wr     = in_acc && (op_t'(op) == OP_WRITE);
	assign ctl.wr_val = cell_value;
	assign ctl.wrap   = wrap_q;
	assign ctl.idx    = cell_index;

	for (genvar i = 0; i < CELLS; i++) begin : g_cell
		localparam int LI = (i == 0) ? CELLS - 1 : i - 1;
		localparam int RI = (i == CELLS - 1) ? 0 : i + 1;
		eca_cell #(
			.IDX  (i),
			.INIT (i == CELLS / 2),
			.END  ((i == 0) || (i == CELLS - 1))
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.rule   (rule_q),
			.left   (row_w[LI]),
			.right  (row_w[RI]),
			.state  (row_w[i]),
			.count  (cnt_w[i]),
			.flip   (flip_w[i])
		);
	end

	// addressable window of the row, zero past the last cell
	for (genvar j = 0; j < IDX_SPAN; j++) begin : g_rd
		if (j < CELLS) begin : g_live
			assign rd_states[j] = row_w[j];
			assign rd_counts[j] = cnt_w[j];
		end else begin : g_pad
			assign rd_states[j] = 1'b0;
			assign rd_counts[j] = '0;
		end
	end

	eca_rdsel u_rdsel (
		.clk      (clk),
		.idx      (idx_q),
		.states   (rd_states),
		.counts   (rd_counts),
		.rd_state (rd_state),
		.rd_count (rd_count)
	);

	eca_tally #(
		.CELLS (CELLS)
	) u_tally (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (step_go),
		.flips  (flip_w),
		.busy   (tally_busy),
		.total  (tally_total)
	);

	// clamp the changed-cell count to the 7-bit field
	assign total_wide = WIDE_W'(tally_total);
	assign total_sat  = (total_wide > WIDE_W'(GEN_MAX)) ? GEN_MAX : total_wide[GEN_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_state_q   <= from_cell_q ? rd_state : 1'b0;
			out_changes_q <= from_cell_q ? rd_count : '0;
			out_gen_q     <= last_gen_q;
		end
	end

	assign out_valid          = out_valid_q;
	assign cell_state         = out_state_q;
	assign cell_changes       = out_changes_q;
	assign generation_changes = out_gen_q;

	// end cells hold through a generation in bounded mode
	assert property (@(posedge clk) disable iff (!arst_n)
		step_go && !wrap_q |=> (row_w[0] == $past(row_w[0])) &&
			(row_w[CELLS-1] == $past(row_w[CELLS-1])))
		else $error("bounded end cell changed on a step");

	// only one item in flight
	assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> in_stall)
		else $error("second item accepted while busy");

	// tally only sweeps while a step waits for it
	assert property (@(posedge clk) disable iff (!arst_n)
		tally_busy |-> (state_q == S_COUNT))
		else $error("tally active outside count state");

	// reported count never exceeds what the row can produce
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (generation_changes <= GEN_CAP))
		else $error("generation count out of range");

endmodule
`default_nettype wire

>>> design/eca_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module eca_cell
	import eca_pkg::*;
#(
	parameter int IDX = 0,
	parameter bit INIT = 1'b0,
	parameter bit END = 1'b0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cell_ctl_t           ctl,
	input  logic [RULE_W-1:0]   rule,
	input  logic                left,
	input  logic                right,
	output logic                state,
	output logic [CNT_W-1:0]    count,
	output logic                flip
);

	logic             state_q;
	logic [CNT_W-1:0] count_q;
	logic             nxt;
	logic             active;
	logic             hit;

	assign nxt    = rule[{left, state_q, right}];
	assign active = ctl.wrap || !END;
	assign flip   = active && (nxt != state_q);
	assign hit    = ctl.wr && (IDX < IDX_SPAN) && (ctl.idx == IDX_W'(IDX));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= INIT;
			count_q <= '0;
		end else if (ctl.step) begin
			if (active)
				state_q <= nxt;
			// saturating change count
			if (flip && (count_q != '1))
				count_q <= count_q + CNT_W'(1);
		end else if (hit) begin
			state_q <= ctl.wr_val;
		end
	end

	assign state = state_q;
	assign count = count_q;

endmodule
`default_nettype wire

>>> design/eca_tally.sv
`timescale 1ns / 1ps
`default_nettype none
module eca_tally
	import eca_pkg::*;
#(
	parameter int CELLS = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [CELLS-1:0]              flips,
	output logic                          busy,
	output logic [$clog2(CELLS+1)-1:0]    total
);

	localparam int NGRP  = (CELLS + GRP - 1) / GRP;
	localparam int SR_W  = NGRP * GRP;
	localparam int GC_W  = $clog2(NGRP + 1);
	localparam int SUM_W = $clog2(CELLS + 1);

	logic [SR_W-1:0]  sr_q;
	logic [GC_W-1:0]  grp_cnt_q;
	logic [SUM_W-1:0] acc_q;
	logic [GRP_W:0]   pop;

	// ones in the lowest group of the shift line
	always_comb begin
		pop = '0;
		for (int b = 0; b < GRP; b++)
			pop = pop + (GRP_W+1)'(sr_q[b]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_cnt_q <= '0;
		end else if (start) begin
			grp_cnt_q <= GC_W'(NGRP);
		end else if (grp_cnt_q != '0) begin
			grp_cnt_q <= grp_cnt_q - GC_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sr_q  <= SR_W'(flips);
			acc_q <= '0;
		end else if (grp_cnt_q != '0) begin
			sr_q  <= sr_q >> GRP;
			acc_q <= acc_q + SUM_W'(pop);
		end
	end

	assign busy  = (grp_cnt_q != '0);
	assign total = acc_q;

endmodule
`default_nettype wire

>>> design/eca_rdsel.sv
`timescale 1ns / 1ps
`default_nettype none
module eca_rdsel
	import eca_pkg::*;
(
	input  logic                 clk,
	input  logic [IDX_W-1:0]     idx,
	input  logic [IDX_SPAN-1:0]  states,
	input  logic [CNT_W-1:0]     counts [IDX_SPAN],
	output logic                 rd_state,
	output logic [CNT_W-1:0]     rd_count
);

	logic             grp_state_s1 [NGRP_RD];
	logic [CNT_W-1:0] grp_count_s1 [NGRP_RD];
	logic             state_s2;
	logic [CNT_W-1:0] count_s2;

	// first level: one entry per group of eight
	always_ff @(posedge clk) begin
		for (int g = 0; g < NGRP_RD; g++) begin
			grp_state_s1[g] <= states[{GRP_W'(g), idx[GRP_W-1:0]}];
			grp_count_s1[g] <= counts[{GRP_W'(g), idx[GRP_W-1:0]}];
		end
	end

	always_ff @(posedge clk) begin
		state_s2 <= grp_state_s1[idx[IDX_W-1:GRP_W]];
		count_s2 <= grp_count_s1[idx[IDX_W-1:GRP_W]];
	end

	assign rd_state = state_s2;
	assign rd_count = count_s2;

endmodule
`default_nettype wire
